FILE: rtl/atcg_pkg.sv
// Shared types and constants for the accelerometer tilt block.
// Has no dependencies; every other file in the block imports it.
package atcg_pkg;

    localparam int TILT_W       = 16;
    localparam int TIME_W       = 24;
    localparam int THR_W        = 16;
    localparam int WARN_W       = 15;
    localparam int ONEG_W       = 15;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int ZW           = 30;
    localparam int ACC_FRAC     = 20;
    localparam int CORDIC_STEPS = 24;
    localparam int SHW          = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WARNING   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_G     = 2'd2;

    localparam logic [THR_W-1:0]  THR_RESET  = 16'd256;
    localparam logic [WARN_W-1:0] WARN_RESET = 15'd7680;
    localparam logic [ONEG_W-1:0] ONEG_RESET = 15'd16384;

    typedef struct packed {
        logic                     done;
        logic signed [TILT_W-1:0] tilt;
    } t_lane_res;

    // Arctangent of 2^-i in degrees with 20 fraction bits.
    function automatic logic signed [ZW-1:0] atan_deg(input logic [SHW-1:0] idx);
        logic signed [ZW-1:0] v;
        unique case (idx)
            5'd0:  v = 30'sd47185920;
            5'd1:  v = 30'sd27855475;
            5'd2:  v = 30'sd14718068;
            5'd3:  v = 30'sd7471121;
            5'd4:  v = 30'sd3750058;
            5'd5:  v = 30'sd1876857;
            5'd6:  v = 30'sd938658;
            5'd7:  v = 30'sd469357;
            5'd8:  v = 30'sd234682;
            5'd9:  v = 30'sd117342;
            5'd10: v = 30'sd58671;
            5'd11: v = 30'sd29335;
            5'd12: v = 30'sd14668;
            5'd13: v = 30'sd7334;
            5'd14: v = 30'sd3667;
            5'd15: v = 30'sd1833;
            5'd16: v = 30'sd917;
            5'd17: v = 30'sd458;
            5'd18: v = 30'sd229;
            5'd19: v = 30'sd115;
            5'd20: v = 30'sd57;
            5'd21: v = 30'sd29;
            5'd22: v = 30'sd14;
            5'd23: v = 30'sd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/atcg_front.sv
// Front end: takes input beats, holds the calibration offsets and forms the
// offset-corrected sample that is pushed into the queue. Uses atcg_pkg.
module atcg_front #(
    parameter int AB = 16,
    parameter int DW = 18
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_req_type,
    input  logic [AB-1:0]                 i_acc_x,
    input  logic [AB-1:0]                 i_acc_y,
    input  logic [AB-1:0]                 i_acc_z,
    input  logic [atcg_pkg::TIME_W-1:0]   i_sample_time,
    input  logic [atcg_pkg::ONEG_W-1:0]   i_one_g,
    input  logic                          i_q_full,
    output logic                          o_push,
    output logic [3*DW+atcg_pkg::TIME_W-1:0] o_push_data
);
    import atcg_pkg::*;

    localparam int OZW = DW - 1;

    logic [AB-1:0]  r_off_x, r_off_y;
    logic [OZW-1:0] r_off_z;
    logic           w_accept;
    logic signed [OZW-1:0] w_cal_z;
    logic signed [DW-1:0]  w_dx, w_dy, w_dz;

    assign o_in_stall = i_q_full;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_cal_z = $signed({{(OZW-AB){i_acc_z[AB-1]}}, i_acc_z})
                   - $signed({{(OZW-ONEG_W){1'b0}}, i_one_g});

    assign w_dx = $signed({{(DW-AB){i_acc_x[AB-1]}}, i_acc_x})
                - $signed({{(DW-AB){r_off_x[AB-1]}}, r_off_x});
    assign w_dy = $signed({{(DW-AB){i_acc_y[AB-1]}}, i_acc_y})
                - $signed({{(DW-AB){r_off_y[AB-1]}}, r_off_y});
    assign w_dz = $signed({{(DW-AB){i_acc_z[AB-1]}}, i_acc_z})
                - $signed({r_off_z[OZW-1], r_off_z});

    assign o_push      = w_accept && !i_req_type;
    assign o_push_data = {w_dx, w_dy, w_dz, i_sample_time};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_x <= '0;
            r_off_y <= '0;
            r_off_z <= '0;
        end else if (w_accept && i_req_type) begin
            r_off_x <= i_acc_x;
            r_off_y <= i_acc_y;
            r_off_z <= w_cal_z;
        end
    end

endmodule

FILE: rtl/atcg_queue.sv
// Two-entry queue that decouples the front end from the angle engine.
// Uses atcg_pkg only by convention; width comes from its parameter.
module atcg_queue #(
    parameter int W = 78
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    output logic         o_valid,
    input  logic         i_pop,
    output logic [W-1:0] o_data
);
    import atcg_pkg::*;

    logic [W-1:0] r_mem [2];
    logic         r_wptr, r_rptr;
    logic [1:0]   r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

FILE: rtl/atcg_lane.sv
// One tilt lane: squares, digit-by-digit square root and a CORDIC vectoring
// pass that yields asin(a / |v|) in degrees. Uses atcg_pkg.
module atcg_lane #(
    parameter int DW  = 18,
    parameter int G   = 7,
    parameter int AFB = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [DW-1:0] i_a,
    input  logic signed [DW-1:0] i_b,
    input  logic signed [DW-1:0] i_c,
    output atcg_pkg::t_lane_res  o_res
);
    import atcg_pkg::*;

    localparam int SQW  = 2 * DW + 1 + 2 * G;
    localparam int SQE  = SQW + (SQW % 2);
    localparam int NIT  = SQE / 2;
    localparam int RW   = NIT;
    localparam int CW   = ((RW > DW + G) ? RW : DW + G) + 3;
    localparam int CNTW = $clog2((NIT > CORDIC_STEPS) ? NIT : CORDIC_STEPS);
    localparam int SH   = ACC_FRAC - AFB;
    localparam int LIM  = ((90 << AFB) > 32767) ? 32767 : (90 << AFB);

    localparam logic [2:0] P_IDLE = 3'd0;
    localparam logic [2:0] P_MUL  = 3'd1;
    localparam logic [2:0] P_SUM  = 3'd2;
    localparam logic [2:0] P_SQRT = 3'd3;
    localparam logic [2:0] P_ROT  = 3'd4;
    localparam logic [2:0] P_RND  = 3'd5;

    logic [2:0]             r_ph;
    logic [CNTW-1:0]        r_cnt;
    logic signed [DW-1:0]   r_a, r_b, r_c;
    logic signed [2*DW-1:0] r_bb, r_cc;
    logic [SQE-1:0]         r_rad;
    logic [RW:0]            r_rem;
    logic [RW-1:0]          r_root;
    logic signed [CW-1:0]   r_x, r_y;
    logic signed [ZW-1:0]   r_z;
    logic signed [TILT_W-1:0] r_tilt;
    logic                   r_done;

    logic [2*DW:0]          w_sum;
    logic [RW+2:0]          w_rem_sh, w_trial;
    logic signed [CW-1:0]   w_xs, w_ys;
    logic signed [ZW-1:0]   w_atan;
    logic [ZW-1:0]          w_mag;
    logic [ZW:0]            w_rnd;
    logic [TILT_W-1:0]      w_sat;

    assign w_sum    = {1'b0, r_bb} + {1'b0, r_cc};
    assign w_rem_sh = {r_rem, r_rad[SQE-1 -: 2]};
    assign w_trial  = {1'b0, r_root, 2'b01};
    assign w_xs     = r_x >>> r_cnt[SHW-1:0];
    assign w_ys     = r_y >>> r_cnt[SHW-1:0];
    assign w_atan   = atan_deg(r_cnt[SHW-1:0]);
    assign w_mag    = r_z[ZW-1] ? ZW'(-r_z) : ZW'(r_z);
    assign w_rnd    = ({1'b0, w_mag} + ((ZW+1)'(1) << (SH - 1))) >> SH;
    assign w_sat    = (w_rnd > (ZW+1)'(LIM)) ? TILT_W'(LIM) : w_rnd[TILT_W-1:0];

    assign o_res.done = r_done;
    assign o_res.tilt = r_tilt;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_c <= i_c;
        end
        unique case (r_ph)
            P_MUL: begin
                r_bb <= r_b * r_b;
                r_cc <= r_c * r_c;
            end
            P_SUM: begin
                r_rad  <= {{(SQE-SQW){1'b0}}, w_sum, {(2*G){1'b0}}};
                r_rem  <= '0;
                r_root <= '0;
            end
            P_SQRT: begin
                r_rad <= {r_rad[SQE-3:0], 2'b00};
                if (w_rem_sh >= w_trial) begin
                    r_rem  <= (RW+1)'(w_rem_sh - w_trial);
                    r_root <= {r_root[RW-2:0], 1'b1};
                end else begin
                    r_rem  <= w_rem_sh[RW:0];
                    r_root <= {r_root[RW-2:0], 1'b0};
                end
                if (r_cnt == CNTW'(NIT - 1)) begin
                    r_x <= $signed({{(CW-RW){1'b0}}, r_root[RW-2:0],
                                    (w_rem_sh >= w_trial)});
                    r_y <= $signed({{(CW-G-DW){r_a[DW-1]}}, r_a, {G{1'b0}}});
                    r_z <= '0;
                end
            end
            P_ROT: begin
                if (!r_y[CW-1]) begin
                    r_x <= r_x + w_ys;
                    r_y <= r_y - w_xs;
                    r_z <= r_z + w_atan;
                end else begin
                    r_x <= r_x - w_ys;
                    r_y <= r_y + w_xs;
                    r_z <= r_z - w_atan;
                end
            end
            P_RND: begin
                r_tilt <= r_z[ZW-1] ? $signed(-w_sat) : $signed(w_sat);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= P_IDLE;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_ph)
                P_IDLE: if (i_start) r_ph <= P_MUL;
                P_MUL:  r_ph <= P_SUM;
                P_SUM: begin
                    r_ph  <= P_SQRT;
                    r_cnt <= '0;
                end
                P_SQRT: begin
                    if (r_cnt == CNTW'(NIT - 1)) begin
                        r_ph  <= P_ROT;
                        r_cnt <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                P_ROT: begin
                    if (r_cnt == CNTW'(CORDIC_STEPS - 1)) begin
                        r_ph <= P_RND;
                    end
                    r_cnt <= r_cnt + 1'b1;
                end
                P_RND: begin
                    r_ph   <= P_IDLE;
                    r_done <= 1'b1;
                end
                default: r_ph <= P_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/atcg_back.sv
// Back end: pops queued samples, runs both tilt lanes, applies the change
// gate and warning check and holds the result register. Uses atcg_pkg, atcg_lane.
module atcg_back #(
    parameter int DW  = 18,
    parameter int G   = 7,
    parameter int AFB = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    input  logic [3*DW+atcg_pkg::TIME_W-1:0] i_q_data,
    output logic                           o_pop,
    input  logic [atcg_pkg::THR_W-1:0]     i_thr,
    input  logic [atcg_pkg::WARN_W-1:0]    i_warn,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [atcg_pkg::TILT_W-1:0] o_tilt_x,
    output logic signed [atcg_pkg::TILT_W-1:0] o_tilt_y,
    output logic [atcg_pkg::TIME_W-1:0]    o_angle_time,
    output logic                           o_tilt_warning
);
    import atcg_pkg::*;

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_RUN  = 2'd1;
    localparam logic [1:0] B_FIN  = 2'd2;

    logic [1:0]               r_st;
    logic                     r_zero;
    logic [TIME_W-1:0]        r_time;
    logic signed [TILT_W-1:0] r_tx, r_ty, r_last_x, r_last_y;
    logic                     r_have_last;
    logic                     r_ov;
    logic signed [TILT_W-1:0] r_ox, r_oy;
    logic [TIME_W-1:0]        r_otime;
    logic                     r_owarn;

    logic signed [DW-1:0]     w_dx, w_dy, w_dz;
    logic [TIME_W-1:0]        w_time;
    t_lane_res                w_res_x, w_res_y;
    logic signed [TILT_W:0]   w_ex, w_ey;
    logic [TILT_W:0]          w_aex, w_aey;
    logic [TILT_W-1:0]        w_atx, w_aty;
    logic                     w_emit, w_warn, w_out_free, w_load;

    assign {w_dx, w_dy, w_dz, w_time} = i_q_data;
    assign o_pop = (r_st == B_IDLE) && i_q_valid;

    atcg_lane #(.DW(DW), .G(G), .AFB(AFB)) u_lane_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (o_pop),
        .i_a     (w_dx),
        .i_b     (w_dy),
        .i_c     (w_dz),
        .o_res   (w_res_x)
    );

    atcg_lane #(.DW(DW), .G(G), .AFB(AFB)) u_lane_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (o_pop),
        .i_a     (w_dy),
        .i_b     (w_dx),
        .i_c     (w_dz),
        .o_res   (w_res_y)
    );

    assign w_ex  = $signed({r_tx[TILT_W-1], r_tx}) - $signed({r_last_x[TILT_W-1], r_last_x});
    assign w_ey  = $signed({r_ty[TILT_W-1], r_ty}) - $signed({r_last_y[TILT_W-1], r_last_y});
    assign w_aex = w_ex[TILT_W] ? (TILT_W+1)'(-w_ex) : (TILT_W+1)'(w_ex);
    assign w_aey = w_ey[TILT_W] ? (TILT_W+1)'(-w_ey) : (TILT_W+1)'(w_ey);
    assign w_atx = r_tx[TILT_W-1] ? TILT_W'(-r_tx) : TILT_W'(r_tx);
    assign w_aty = r_ty[TILT_W-1] ? TILT_W'(-r_ty) : TILT_W'(r_ty);

    assign w_emit = !r_have_last || (w_aex >= {1'b0, i_thr}) || (w_aey >= {1'b0, i_thr});
    assign w_warn = (w_atx > {1'b0, i_warn}) || (w_aty > {1'b0, i_warn});
    assign w_out_free = !r_ov || !i_out_stall;
    assign w_load = (r_st == B_FIN) && w_emit && w_out_free;

    assign o_out_valid    = r_ov;
    assign o_tilt_x       = r_ox;
    assign o_tilt_y       = r_oy;
    assign o_angle_time   = r_otime;
    assign o_tilt_warning = r_owarn;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_zero <= (w_dx == '0) && (w_dy == '0) && (w_dz == '0);
            r_time <= w_time;
        end
        if (r_st == B_RUN && w_res_x.done) begin
            r_tx <= r_zero ? '0 : w_res_x.tilt;
            r_ty <= r_zero ? '0 : w_res_y.tilt;
        end
        if (w_load) begin
            r_ox    <= r_tx;
            r_oy    <= r_ty;
            r_otime <= r_time;
            r_owarn <= w_warn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= B_IDLE;
            r_ov        <= 1'b0;
            r_have_last <= 1'b0;
            r_last_x    <= '0;
            r_last_y    <= '0;
        end else begin
            if (w_load) begin
                r_ov        <= 1'b1;
                r_last_x    <= r_tx;
                r_last_y    <= r_ty;
                r_have_last <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            unique case (r_st)
                B_IDLE: if (o_pop) r_st <= B_RUN;
                B_RUN:  if (w_res_x.done) r_st <= B_FIN;
                B_FIN:  if (!w_emit || w_out_free) r_st <= B_IDLE;
                default: r_st <= B_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/accel_tilt_angle_with_change_gate_top.sv
// Tilt inclinometer: a measure beat passes through the queue, the square root
// steps and the 24 CORDIC steps in each lane and then the change gate; one item is
// worked at a time, so the back end pops no new sample until it is through with
// the last. Calibrate beats only load the calibration offsets. Synchronous
// active-low reset clears offsets, the change gate history and restores the
// register defaults.
module accel_tilt_angle_with_change_gate_top #(
    parameter int ACCEL_BITS      = 16,
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_req_type,
    input  logic [ACCEL_BITS-1:0]              i_acc_x,
    input  logic [ACCEL_BITS-1:0]              i_acc_y,
    input  logic [ACCEL_BITS-1:0]              i_acc_z,
    input  logic [atcg_pkg::TIME_W-1:0]        i_sample_time,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [atcg_pkg::TILT_W-1:0] o_tilt_x,
    output logic signed [atcg_pkg::TILT_W-1:0] o_tilt_y,
    output logic [atcg_pkg::TIME_W-1:0]        o_angle_time,
    output logic                               o_tilt_warning,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [atcg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [atcg_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import atcg_pkg::*;

    localparam int DW = ((ACCEL_BITS > 16) ? ACCEL_BITS : 16) + 2;
    localparam int G  = ((24 - ACCEL_BITS) / 2) + 3;
    localparam int QW = 3 * DW + TIME_W;

    logic [THR_W-1:0]  r_thr;
    logic [WARN_W-1:0] r_warn;
    logic [ONEG_W-1:0] r_one_g;

    logic          w_q_full, w_push, w_pop, w_q_valid;
    logic [QW-1:0] w_push_data, w_q_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= THR_RESET;
            r_warn  <= WARN_RESET;
            r_one_g <= ONEG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD: r_thr   <= i_cfg_data;
                CFG_WARNING:   r_warn  <= i_cfg_data[WARN_W-1:0];
                CFG_ONE_G:     r_one_g <= i_cfg_data[ONEG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    atcg_front #(.AB(ACCEL_BITS), .DW(DW)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_acc_x       (i_acc_x),
        .i_acc_y       (i_acc_y),
        .i_acc_z       (i_acc_z),
        .i_sample_time (i_sample_time),
        .i_one_g       (r_one_g),
        .i_q_full      (w_q_full),
        .o_push        (w_push),
        .o_push_data   (w_push_data)
    );

    atcg_queue #(.W(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_data  (w_q_data)
    );

    atcg_back #(.DW(DW), .G(G), .AFB(ANGLE_FRAC_BITS)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_q_valid),
        .i_q_data       (w_q_data),
        .o_pop          (w_pop),
        .i_thr          (r_thr),
        .i_warn         (r_warn),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_tilt_x       (o_tilt_x),
        .o_tilt_y       (o_tilt_y),
        .o_angle_time   (o_angle_time),
        .o_tilt_warning (o_tilt_warning)
    );

endmodule

FILE: rtl/atcg_checker.sv
// Port-level checks for the tilt block, bound to the top level.
// Uses atcg_pkg and sees only the top-level ports.
module atcg_checker #(
    parameter int ANGLE_FRAC_BITS = 8
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic signed [atcg_pkg::TILT_W-1:0] o_tilt_x,
    input logic signed [atcg_pkg::TILT_W-1:0] o_tilt_y,
    input logic [atcg_pkg::TIME_W-1:0]        o_angle_time,
    input logic                               o_tilt_warning
);
    import atcg_pkg::*;

    localparam int LIM = ((90 << ANGLE_FRAC_BITS) > 32767) ? 32767 : (90 << ANGLE_FRAC_BITS);

    // A stalled result beat keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_tilt_x)
            && $stable(o_tilt_y) && $stable(o_angle_time) && $stable(o_tilt_warning))
        else $error("result beat changed while stalled");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Tilts stay within the saturation limit of a right angle.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_tilt_x <= TILT_W'(LIM)) && (o_tilt_x >= -TILT_W'(LIM))
            && (o_tilt_y <= TILT_W'(LIM)) && (o_tilt_y >= -TILT_W'(LIM)))
        else $error("tilt beyond saturation limit");

endmodule

bind accel_tilt_angle_with_change_gate_top atcg_checker #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
) u_atcg_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_tilt_x       (o_tilt_x),
    .o_tilt_y       (o_tilt_y),
    .o_angle_time   (o_angle_time),
    .o_tilt_warning (o_tilt_warning)
);
